[sv/bfcd_pkg.sv]
// Shared widths and constants of the barometric floor-change detector.
`timescale 1ns / 1ps
`default_nettype none

package bfcd_pkg;

    localparam int PRESS_W  = 24;
    localparam int LEVEL_W  = 16;
    localparam int MARGIN_W = 32;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 32'd1016524;

endpackage

`default_nettype wire

[sv/bfcd_item_if.sv]
// Channel interface for input sensor event transactions.
`timescale 1ns / 1ps
`default_nettype none

interface bfcd_item_if;

    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [bfcd_pkg::PRESS_W-1:0]  pressure;
    logic [bfcd_pkg::LEVEL_W-1:0]  level_in;

    modport source (
        output valid,
        output func,
        output pressure,
        output level_in,
        input  ready
    );

    modport sink (
        input  valid,
        input  func,
        input  pressure,
        input  level_in,
        output ready
    );

endinterface

`default_nettype wire

[sv/bfcd_result_if.sv]
// Channel interface for confirmed floor level transactions.
`timescale 1ns / 1ps
`default_nettype none

interface bfcd_result_if;

    logic                          valid;
    logic                          ready;
    logic [bfcd_pkg::LEVEL_W-1:0]  level_out;

    modport source (
        output valid,
        output level_out,
        input  ready
    );

    modport sink (
        input  valid,
        input  level_out,
        output ready
    );

endinterface

`default_nettype wire

[sv/baro_floor_change_detector.sv]
// Top level of the barometric floor-change detector.
//
// Channel   Dir  Payload                         Handshake
// item      in   func, pressure, level_in        valid / ready
// result    out  level_out                       valid / ready
// margin    in   margin_data (32 bit)            margin_we, no wait
//
// The first transaction goes straight to S_CHECK. A barometer sample adds S_OLDRD,
// S_RECRD and S_MOVE for two reads of the single ring read port; a window comparison
// adds S_DIFF, S_MUL_LO and S_MUL_HI for the two partial products of the margin multiplier.
// Reset clears counts, sums, level and slot at once; the ring needs no clearing pass.
// A waiting result does not block the next input transaction; only the final step
// of the following transaction waits until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module baro_floor_change_detector #(
    parameter int CHUNK = 100
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    bfcd_item_if.sink                           item,
    bfcd_result_if.source                       result,
    input  wire logic                           margin_we,
    input  wire logic [bfcd_pkg::MARGIN_W-1:0]  margin_data
);

    localparam int RD = 2 * (CHUNK + 1);
    localparam int AW = $clog2(RD);
    localparam int XW = AW + 1;
    localparam int CW = $clog2(CHUNK + 2);
    localparam int BW = CW + 1;
    localparam int SW = bfcd_pkg::PRESS_W + CW;
    localparam int PB = SW + CW;
    localparam int PW = bfcd_pkg::PRESS_W;
    localparam int LW = bfcd_pkg::LEVEL_W;
    localparam int MW = bfcd_pkg::MARGIN_W;

    localparam logic [CW-1:0] CHUNK_C  = CW'(CHUNK);
    localparam logic [CW-1:0] FULL_C   = CW'(CHUNK + 1);
    localparam logic [AW-1:0] LAST_C   = AW'(RD - 1);
    localparam logic [XW-1:0] DEPTH_X  = XW'(RD);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OLDRD,
        S_RECRD,
        S_MOVE,
        S_CHECK,
        S_DIFF,
        S_MUL_LO,
        S_MUL_HI
    } state_t;

    state_t          state_reg, state_next;
    logic [MW-1:0]   margin_reg, margin_next;
    logic [AW-1:0]   slot_reg, slot_next;
    logic [CW-1:0]   recent_count_reg, recent_count_next;
    logic [CW-1:0]   older_count_reg, older_count_next;
    logic [SW-1:0]   recent_sum_reg, recent_sum_next;
    logic [SW-1:0]   older_sum_reg, older_sum_next;
    logic [LW-1:0]   confirmed_reg, confirmed_next;
    logic            started_reg, started_next;
    logic            first_reg, first_next;
    logic            func_reg, func_next;
    logic [PW-1:0]   pressure_reg, pressure_next;
    logic [LW-1:0]   level_reg, level_next;
    logic [PB-1:0]   a_reg, a_next;
    logic [PB-1:0]   b_reg, b_next;
    logic [PB-1:0]   diff_reg, diff_next;
    logic [PB-1:0]   min_reg, min_next;
    logic [31:0]     q_lo_reg, q_lo_next;
    logic            out_valid_reg, out_valid_next;
    logic [LW-1:0]   out_level_reg, out_level_next;

    logic            ring_we;
    logic            ring_re;
    logic [AW-1:0]   ring_raddr;
    logic [PW-1:0]   ring_rdata;
    logic [SW-1:0]   rd_ext;
    logic [SW-1:0]   press_ext;
    logic [AW-1:0]   pos_old;
    logic [AW-1:0]   pos_rec;
    logic [63:0]     min_ext;
    logic [63:0]     prod_lo;
    logic [63:0]     prod_hi;
    logic [64:0]     bound;
    logic            exceeds;
    logic            filled;
    logic            out_free;
    logic            done;
    logic            update;
    logic [LW-1:0]   res_level;

    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] slot,
                                               input logic [BW-1:0] back);
        logic [XW-1:0] slot_x;
        logic [XW-1:0] back_x;
        logic [XW-1:0] pos_x;
        slot_x = XW'(slot);
        back_x = XW'(back);
        if (back_x == DEPTH_X)
        begin
            pos_x = slot_x;
        end
        else if (slot_x >= back_x)
        begin
            pos_x = slot_x - back_x;
        end
        else
        begin
            pos_x = slot_x + DEPTH_X - back_x;
        end
        return pos_x[AW-1:0];
    endfunction

    bfcd_ring #(
        .DEPTH (RD),
        .AW    (AW)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (slot_reg),
        .wdata (pressure_reg),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    assign pos_old   = ring_pos(slot_reg, BW'(recent_count_reg) + BW'(older_count_reg));
    assign pos_rec   = ring_pos(slot_reg, BW'(recent_count_reg));
    assign rd_ext    = SW'(ring_rdata);
    assign press_ext = SW'(pressure_reg);
    assign min_ext   = 64'(min_reg);
    assign prod_lo   = 64'(min_ext[31:0]) * 64'(margin_reg);
    assign prod_hi   = 64'(min_ext[63:32]) * 64'(margin_reg);
    assign bound     = 65'(prod_hi) + 65'(q_lo_reg);
    assign exceeds   = 65'(diff_reg) > bound;
    assign filled    = (recent_count_reg > CHUNK_C) && (older_count_reg >= CHUNK_C);
    assign out_free  = !out_valid_reg || result.ready;

    assign item.ready       = (state_reg == S_IDLE);
    assign result.valid     = out_valid_reg;
    assign result.level_out = out_level_reg;

    always_comb
    begin
        state_next        = state_reg;
        margin_next       = margin_reg;
        slot_next         = slot_reg;
        recent_count_next = recent_count_reg;
        older_count_next  = older_count_reg;
        recent_sum_next   = recent_sum_reg;
        older_sum_next    = older_sum_reg;
        confirmed_next    = confirmed_reg;
        started_next      = started_reg;
        first_next        = first_reg;
        func_next         = func_reg;
        pressure_next     = pressure_reg;
        level_next        = level_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        diff_next         = diff_reg;
        min_next          = min_reg;
        q_lo_next         = q_lo_reg;
        out_valid_next    = out_valid_reg;
        out_level_next    = out_level_reg;
        ring_we           = 1'b0;
        ring_re           = 1'b0;
        ring_raddr        = pos_old;
        done              = 1'b0;
        update            = 1'b0;
        res_level         = confirmed_reg;

        if (margin_we)
        begin
            margin_next = margin_data;
        end

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    func_next     = item.func;
                    pressure_next = item.pressure;
                    level_next    = item.level_in;
                    first_next    = !started_reg;
                    started_next  = 1'b1;
                    state_next    = (started_reg && item.func) ? S_OLDRD : S_CHECK;
                end
            end
            S_OLDRD:
            begin
                ring_re    = 1'b1;
                ring_raddr = pos_old;
                state_next = S_RECRD;
            end
            S_RECRD:
            begin
                ring_re    = 1'b1;
                ring_raddr = pos_rec;
                if (older_count_reg > CHUNK_C)
                begin
                    older_sum_next   = older_sum_reg - rd_ext;
                    older_count_next = older_count_reg - 1'b1;
                end
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                ring_we = 1'b1;
                if (recent_count_reg > CHUNK_C)
                begin
                    recent_sum_next  = recent_sum_reg - rd_ext + press_ext;
                    older_sum_next   = older_sum_reg + rd_ext;
                    older_count_next = older_count_reg + 1'b1;
                end
                else
                begin
                    recent_sum_next   = recent_sum_reg + press_ext;
                    recent_count_next = recent_count_reg + 1'b1;
                end
                slot_next  = (slot_reg == LAST_C) ? '0 : slot_reg + 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (first_reg)
                begin
                    done      = 1'b1;
                    res_level = level_reg;
                end
                else if (!filled)
                begin
                    done      = 1'b1;
                    update    = 1'b1;
                    res_level = level_reg;
                end
                else if ((level_reg == confirmed_reg) || (recent_sum_reg == '0)
                         || (older_sum_reg == '0))
                begin
                    done = 1'b1;
                end
                else
                begin
                    a_next     = PB'(recent_sum_reg) * PB'(older_count_reg);
                    b_next     = PB'(older_sum_reg) * PB'(recent_count_reg);
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                if (a_reg == b_reg)
                begin
                    done = 1'b1;
                end
                else
                begin
                    diff_next  = (a_reg > b_reg) ? a_reg - b_reg : b_reg - a_reg;
                    min_next   = (a_reg > b_reg) ? b_reg : a_reg;
                    state_next = S_MUL_LO;
                end
            end
            S_MUL_LO:
            begin
                q_lo_next  = prod_lo[63:32];
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                done = 1'b1;
                if (exceeds)
                begin
                    update    = 1'b1;
                    res_level = level_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done && out_free)
        begin
            out_valid_next = 1'b1;
            out_level_next = res_level;
            state_next     = S_IDLE;
            if (update)
            begin
                confirmed_next = level_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            margin_reg       <= bfcd_pkg::MARGIN_RESET;
            slot_reg         <= '0;
            recent_count_reg <= '0;
            older_count_reg  <= '0;
            recent_sum_reg   <= '0;
            older_sum_reg    <= '0;
            confirmed_reg    <= '0;
            started_reg      <= 1'b0;
            first_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            margin_reg       <= margin_next;
            slot_reg         <= slot_next;
            recent_count_reg <= recent_count_next;
            older_count_reg  <= older_count_next;
            recent_sum_reg   <= recent_sum_next;
            older_sum_reg    <= older_sum_next;
            confirmed_reg    <= confirmed_next;
            started_reg      <= started_next;
            first_reg        <= first_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        pressure_reg  <= pressure_next;
        level_reg     <= level_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        diff_reg      <= diff_next;
        min_reg       <= min_next;
        q_lo_reg      <= q_lo_next;
        out_level_reg <= out_level_next;
    end

`ifndef SYNTHESIS
    // The windows never hold more than CHUNK+1 samples each.
    assert property (@(posedge clk) disable iff (!rst_n)
        (recent_count_reg <= FULL_C) && (older_count_reg <= FULL_C))
    else $error("window count above its capacity");

    // Samples reach the older window only once the recent window is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (older_count_reg != '0) |-> (recent_count_reg == FULL_C))
    else $error("older window filled while recent window is short");

    // The write slot stays inside the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= LAST_C)
    else $error("write slot outside the ring");

    // Once the first transaction is seen, the block stays started.
    assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |=> started_reg)
    else $error("started flag dropped");

    // A ring write only follows the two reads of a barometer sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        ring_we |-> (func_reg && $past(state_reg) == S_RECRD))
    else $error("ring write out of sequence");
`endif

endmodule

`default_nettype wire

[sv/bfcd_ring.sv]
// Sample ring memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bfcd_ring #(
    parameter int DEPTH = 202,
    parameter int AW    = 8
) (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [AW-1:0]                 waddr,
    input  wire logic [bfcd_pkg::PRESS_W-1:0]  wdata,
    input  wire logic                          re,
    input  wire logic [AW-1:0]                 raddr,
    output      logic [bfcd_pkg::PRESS_W-1:0]  rdata
);

    logic [bfcd_pkg::PRESS_W-1:0] mem [DEPTH];
    logic [bfcd_pkg::PRESS_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[dv/baro_floor_change_detector_tb.sv]
// Self-checking testbench for the barometric floor-change detector.
`timescale 1ns / 1ps

module baro_floor_change_detector_tb;

    localparam int CHUNK      = 100;
    localparam int RING_LEN   = 2 * (CHUNK + 1);
    localparam int SCRIPT_LEN = 14;
    localparam int PW         = bfcd_pkg::PRESS_W;
    localparam int LW         = bfcd_pkg::LEVEL_W;
    localparam int MW         = bfcd_pkg::MARGIN_W;

    typedef struct packed {
        logic          func;
        logic [PW-1:0] pressure;
        logic [LW-1:0] level;
    } sensor_event_t;

    typedef struct packed {
        sensor_event_t ev;
        logic          known;
        logic [LW-1:0] level_lit;
    } script_row_t;

    typedef enum int {
        PRESS_STEADY,
        PRESS_WILD,
        PRESS_ZERO
    } press_style_t;

    logic          clk;
    logic          rst_n;
    logic          margin_we;
    logic [MW-1:0] margin_data;

    bfcd_item_if   item_ch ();
    bfcd_result_if result_ch ();

    baro_floor_change_detector #(
        .CHUNK (CHUNK)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .margin_we   (margin_we),
        .margin_data (margin_data)
    );

    logic [PW-1:0]   baro_ring [RING_LEN];
    int unsigned     ring_wr;
    int unsigned     new_cnt;
    int unsigned     old_cnt;
    longint unsigned new_sum;
    longint unsigned old_sum;
    logic [LW-1:0]   held_level;
    bit              seen_first;
    logic [MW-1:0]   margin_now;

    logic [LW-1:0]   pending_levels [$];
    script_row_t     script [SCRIPT_LEN];
    int              events_sent;
    int              levels_checked;
    int              error_count;
    int              base_press;
    logic [LW-1:0]   last_level;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int unsigned ring_back(input int unsigned back);
        return (ring_wr + RING_LEN - (back % RING_LEN)) % RING_LEN;
    endfunction

    function automatic logic [LW-1:0] confirm_floor(input sensor_event_t ev);
        int unsigned  pos;
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [127:0] scale;
        if (!seen_first)
        begin
            seen_first = 1'b1;
            return ev.level;
        end
        if (ev.func)
        begin
            if (old_cnt > CHUNK)
            begin
                pos = ring_back(new_cnt + old_cnt);
                old_sum -= baro_ring[pos];
                old_cnt--;
            end
            if (new_cnt > CHUNK)
            begin
                pos = ring_back(new_cnt);
                new_sum -= baro_ring[pos];
                old_sum += baro_ring[pos];
                new_cnt--;
                old_cnt++;
            end
            baro_ring[ring_wr] = ev.pressure;
            new_sum += ev.pressure;
            new_cnt++;
            ring_wr = (ring_wr + 1) % RING_LEN;
        end
        if (new_cnt > CHUNK && old_cnt >= CHUNK)
        begin
            if (held_level != ev.level && new_sum != 0 && old_sum != 0)
            begin
                lhs   = new_sum;
                lhs   = lhs * old_cnt;
                rhs   = old_sum;
                rhs   = rhs * new_cnt;
                scale = 64'h1_0000_0000;
                scale = scale + margin_now;
                if ((lhs << 32) > rhs * scale || (rhs << 32) > lhs * scale)
                    held_level = ev.level;
            end
        end
        else
        begin
            held_level = ev.level;
        end
        return held_level;
    endfunction

    task automatic offer_event(input sensor_event_t ev, input logic known,
                               input logic [LW-1:0] level_lit);
        logic [LW-1:0] predicted;
        if (!(events_sent >= 520 && events_sent < 660) && $urandom_range(99) < 33)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.func     <= ev.func;
        item_ch.pressure <= ev.pressure;
        item_ch.level_in <= ev.level;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
            @(posedge clk);
        predicted = confirm_floor(ev);
        pending_levels.insert(pending_levels.size(), known ? level_lit : predicted);
        events_sent++;
    endtask

    task automatic set_margin(input logic [MW-1:0] value);
        item_ch.valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        margin_we   <= 1'b1;
        margin_data <= value;
        @(posedge clk);
        margin_we  <= 1'b0;
        margin_now = value;
    endtask

    task automatic run_phase(input int count, input press_style_t style);
        sensor_event_t ev;
        int            roll;
        for (int n = 0; n < count; n++)
        begin
            ev.func = ($urandom_range(99) < ((style == PRESS_ZERO) ? 95 : 85));
            if (!ev.func || style == PRESS_WILD)
            begin
                ev.pressure = PW'($urandom);
            end
            else if (style == PRESS_ZERO)
            begin
                ev.pressure = '0;
            end
            else
            begin
                roll = int'($urandom_range(79));
                if (roll == 0)
                    base_press = int'($urandom_range(24'hE00000, 24'h100000));
                else if (roll == 1)
                    base_press = base_press + int'($urandom_range(8192)) - 4096;
                if (base_press < 24'h100000)
                    base_press = 24'h100000;
                if (base_press > 24'hE00000)
                    base_press = 24'hE00000;
                ev.pressure = PW'(base_press + int'($urandom_range(255)));
            end
            roll = int'($urandom_range(99));
            if (roll < 60)
                ev.level = last_level;
            else if (roll < 90)
                ev.level = LW'($urandom_range(7));
            else
                ev.level = LW'($urandom);
            last_level = ev.level;
            offer_event(ev, 1'b0, '0);
        end
    endtask

    initial
    begin
        logic [LW-1:0] expected_level;
        bit            held_off;
        held_off        = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                if (pending_levels.size() == 0)
                begin
                    $error("level_out: unexpected transaction, actual %0d",
                           result_ch.level_out);
                    error_count++;
                end
                else
                begin
                    expected_level = pending_levels[0];
                    pending_levels.delete(0);
                    if (result_ch.level_out !== expected_level)
                    begin
                        $error("level_out: expected %0d, actual %0d",
                               expected_level, result_ch.level_out);
                        error_count++;
                    end
                    levels_checked++;
                end
            end
            if (!held_off && levels_checked == 200)
            begin
                held_off = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (120) @(posedge clk);
            end
            if (levels_checked >= 500 && levels_checked < 660)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(99) >= 33);
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        margin_we        = 1'b0;
        margin_data      = '0;
        item_ch.valid    = 1'b0;
        item_ch.func     = 1'b0;
        item_ch.pressure = '0;
        item_ch.level_in = '0;
        for (int i = 0; i < RING_LEN; i++)
            baro_ring[i] = '0;
        ring_wr        = 0;
        new_cnt        = 0;
        old_cnt        = 0;
        new_sum        = 0;
        old_sum        = 0;
        held_level     = '0;
        seen_first     = 1'b0;
        margin_now     = bfcd_pkg::MARGIN_RESET;
        events_sent    = 0;
        levels_checked = 0;
        error_count    = 0;
        base_press     = 24'h900000;
        last_level     = '0;

        // The first transaction only passes its level through.
        script[0]  = '{'{1'b1, 24'hFFFFFF, 16'hFFFF}, 1'b1, 16'hFFFF};
        script[1]  = '{'{1'b0, 24'h000000, 16'h0000}, 1'b1, 16'h0000};
        script[2]  = '{'{1'b1, 24'hFFFFFF, 16'h0001}, 1'b1, 16'h0001};
        script[3]  = '{'{1'b1, 24'h000000, 16'hFFFF}, 1'b1, 16'hFFFF};
        script[4]  = '{'{1'b0, 24'hFFFFFF, 16'hFFFF}, 1'b1, 16'hFFFF};
        script[5]  = '{'{1'b1, 24'h800000, 16'h8000}, 1'b0, 16'h0000};
        script[6]  = '{'{1'b1, 24'h7FFFFF, 16'h7FFF}, 1'b0, 16'h0000};
        script[7]  = '{'{1'b0, 24'h555555, 16'hAAAA}, 1'b0, 16'h0000};
        script[8]  = '{'{1'b1, 24'hAAAAAA, 16'h5555}, 1'b0, 16'h0000};
        script[9]  = '{'{1'b1, 24'h000001, 16'h0002}, 1'b0, 16'h0000};
        script[10] = '{'{1'b1, 24'hFFFFFE, 16'h0003}, 1'b0, 16'h0000};
        script[11] = '{'{1'b0, 24'h123456, 16'h0003}, 1'b0, 16'h0000};
        script[12] = '{'{1'b1, 24'h900000, 16'h0000}, 1'b0, 16'h0000};
        script[13] = '{'{1'b1, 24'h900010, 16'h0000}, 1'b0, 16'h0000};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_margin(bfcd_pkg::MARGIN_RESET);
        for (int r = 0; r < SCRIPT_LEN; r++)
            offer_event(script[r].ev, script[r].known, script[r].level_lit);
        run_phase(300, PRESS_STEADY);

        set_margin('0);
        run_phase(120, PRESS_STEADY);

        set_margin('1);
        run_phase(100, PRESS_WILD);
        run_phase(60, PRESS_STEADY);

        set_margin($urandom);
        run_phase(130, PRESS_ZERO);
        run_phase(40, PRESS_STEADY);

        set_margin($urandom_range(4_000_000, 1));
        run_phase(100, PRESS_STEADY);

        item_ch.valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
sv/bfcd_pkg.sv
sv/bfcd_item_if.sv
sv/bfcd_result_if.sv
sv/bfcd_ring.sv
sv/baro_floor_change_detector.sv
dv/baro_floor_change_detector_tb.sv
